### hw/rtl/swds_pkg.sv
`timescale 1ns / 1ps
// constants and field widths for the square-wave divider search core
// no dependencies

package swds_pkg;

    localparam int HZ_W     = 25;
    localparam int BASE_W   = 26;
    localparam int SEL_W    = 2;
    localparam int OUT_W    = 9;
    localparam int ACH_W    = 33;
    localparam int ACH_FRAC = 8;

    // shared multiplier: wide operand by narrow operand
    localparam int MUL_A_W  = 36;
    localparam int MUL_B_W  = 10;
    localparam int PW       = MUL_A_W + MUL_B_W;

    // square root search span and final division
    localparam int SQ_W     = 10;
    localparam int DV_W     = 17;
    localparam int DEN_W    = DV_W + 1;
    localparam int NUM_W    = 34;
    localparam int CNT_W    = 6;

    localparam int BASE_SHIFT = 17;

    localparam logic [BASE_W-1:0] BASE_48M = 26'd48000000;
    localparam logic [BASE_W-1:0] BASE_12M = 26'd12000000;
    localparam logic [BASE_W-1:0] BASE_4M  = 26'd4000000;
    localparam logic [BASE_W-1:0] BASE_1M  = 26'd1000000;

    localparam logic [HZ_W-1:0] THR_48M = HZ_W'(BASE_48M >> BASE_SHIFT);
    localparam logic [HZ_W-1:0] THR_12M = HZ_W'(BASE_12M >> BASE_SHIFT);
    localparam logic [HZ_W-1:0] THR_4M  = HZ_W'(BASE_4M >> BASE_SHIFT);

    localparam logic [HZ_W-1:0] HZ_CEIL  = 25'd24000000;
    localparam logic [HZ_W-1:0] HZ_FLOOR = 25'd8;

    localparam logic [SEL_W-1:0] SEL_1M  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_4M  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_12M = 2'd2;
    localparam logic [SEL_W-1:0] SEL_48M = 2'd3;

    typedef logic [SQ_W:0] sq_span_t;
    localparam sq_span_t SQ_SPAN = sq_span_t'(1) << SQ_W;

endpackage

### hw/rtl/square_wave_divider_search_core.sv
`timescale 1ns / 1ps
// square-wave divider search: picks clock base, divisor and timer value
// depends on swds_pkg

// One request beat is taken at a time; req_stall stays high until the result
// has been moved into the output register. All multiplications run through one
// shared 36x10 multiplier with a registered product, stepped by a sequencer
// through the lower divisor bound, the square root bound, a value search for
// each divisor tried, and the closing bit-serial division of the achieved
// frequency. Requests below 8 Hz skip the search. A finished result waits in
// the output register while the next request is worked on.
module square_wave_divider_search_core
    import swds_pkg::*;
#(
    parameter int MAX_FACTOR = 256
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [HZ_W-1:0]    requested_hz,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [SEL_W-1:0]   base_select,
    output logic [OUT_W-1:0]   divisor,
    output logic [OUT_W-1:0]   timer_value,
    output logic [ACH_W-1:0]   achieved_hz
);

    localparam int QW    = $clog2(MAX_FACTOR) + 1;
    localparam int BIT_W = $clog2(QW);

    localparam logic [QW-1:0]      MF_Q    = QW'(MAX_FACTOR);
    localparam logic [MUL_B_W-1:0] MF_B    = MUL_B_W'(MAX_FACTOR);
    localparam logic [SQ_W:0]      MF_SQ   = (SQ_W+1)'(MAX_FACTOR);
    localparam logic [BIT_W-1:0]   BIT_TOP = BIT_W'(QW - 1);
    localparam logic [CNT_W-1:0]   CNT_TOP = CNT_W'(NUM_W - 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LOD_MUL = 5'd1;
    localparam logic [4:0] S_LOD_CAP = 5'd2;
    localparam logic [4:0] S_LOQ_MUL = 5'd3;
    localparam logic [4:0] S_LOQ_CMP = 5'd4;
    localparam logic [4:0] S_SQ_MUL1 = 5'd5;
    localparam logic [4:0] S_SQ_MUL2 = 5'd6;
    localparam logic [4:0] S_SQ_CMP  = 5'd7;
    localparam logic [4:0] S_D_START = 5'd8;
    localparam logic [4:0] S_TD_MUL  = 5'd9;
    localparam logic [4:0] S_TD_CAP  = 5'd10;
    localparam logic [4:0] S_BS_MUL  = 5'd11;
    localparam logic [4:0] S_BS_CMP  = 5'd12;
    localparam logic [4:0] S_EH_MUL  = 5'd13;
    localparam logic [4:0] S_EH_CMP  = 5'd14;
    localparam logic [4:0] S_EL_MUL  = 5'd15;
    localparam logic [4:0] S_EL_CMP  = 5'd16;
    localparam logic [4:0] S_FD_MUL  = 5'd17;
    localparam logic [4:0] S_FD_CAP  = 5'd18;
    localparam logic [4:0] S_FD_DIV  = 5'd19;
    localparam logic [4:0] S_RESULT  = 5'd20;

    // control
    logic [4:0]         state_reg, state_next;
    logic               res_valid_reg, res_valid_next;

    // datapath
    logic [BASE_W-1:0]  twohz_reg, twohz_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [SEL_W-1:0]   sel_reg, sel_next;
    logic [OUT_W-1:0]   best_d_reg, best_d_next;
    logic [OUT_W-1:0]   best_v_reg, best_v_next;
    logic [PW-1:0]      best_err_reg, best_err_next;
    logic [MUL_A_W-1:0] div_reg, div_next;
    logic [QW-1:0]      q_reg, q_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [SQ_W-1:0]    sq_lo_reg, sq_lo_next;
    logic [SQ_W:0]      sq_hi_reg, sq_hi_next;
    logic [QW-1:0]      d_reg, d_next;
    logic [QW-1:0]      d_hi_reg, d_hi_next;
    logic [MUL_A_W-1:0] td_reg, td_next;
    logic [QW-1:0]      lo_reg, lo_next;
    logic [QW-1:0]      hi_reg, hi_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]      prod_reg;
    logic [SEL_W-1:0]   out_sel_reg, out_sel_next;
    logic [OUT_W-1:0]   out_d_reg, out_d_next;
    logic [OUT_W-1:0]   out_v_reg, out_v_next;
    logic [ACH_W-1:0]   out_ach_reg, out_ach_next;

    // combinational
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [HZ_W-1:0]    hz_c;
    logic [BASE_W-1:0]  twohz_c;
    logic [BASE_W-1:0]  base_c;
    logic [SEL_W-1:0]   sel_c;
    logic [QW-1:0]      loq_trial;
    logic [SQ_W-1:0]    sq_mid;
    logic [QW-1:0]      bs_mid;
    logic [SQ_W:0]      d_hi_wide;
    logic [QW-1:0]      d_hi_c;
    logic [PW-1:0]      base_ext;
    logic               p_lt;
    logic               p_gt;
    logic [PW-1:0]      p_err;
    logic [PW-1:0]      err_new;
    logic [DEN_W:0]     div_t;
    logic               div_ge;
    logic               res_take;
    logic               out_free;

    assign req_stall   = (state_reg != S_IDLE);
    assign res_valid   = res_valid_reg;
    assign base_select = out_sel_reg;
    assign divisor     = out_d_reg;
    assign timer_value = out_v_reg;
    assign achieved_hz = out_ach_reg;

    always_comb
    begin
        // request clamp and clock base choice
        priority if (requested_hz == '0)
            hz_c = HZ_W'(1);
        else if (requested_hz > HZ_CEIL)
            hz_c = HZ_CEIL;
        else
            hz_c = requested_hz;

        priority if (hz_c > THR_48M)
        begin
            base_c = BASE_48M;
            sel_c  = SEL_48M;
        end
        else if (hz_c > THR_12M)
        begin
            base_c = BASE_12M;
            sel_c  = SEL_12M;
        end
        else if (hz_c > THR_4M)
        begin
            base_c = BASE_4M;
            sel_c  = SEL_4M;
        end
        else
        begin
            base_c = BASE_1M;
            sel_c  = SEL_1M;
        end
        twohz_c = {hz_c, 1'b0};

        loq_trial = q_reg | (QW'(1) << bit_reg);
        sq_mid    = SQ_W'(({1'b0, sq_lo_reg} + sq_hi_reg) >> 1);
        bs_mid    = QW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

        d_hi_wide = {1'b0, sq_lo_reg} + (SQ_W+1)'(1);
        d_hi_c    = (d_hi_wide > MF_SQ) ? MF_Q : QW'(d_hi_wide);

        base_ext = PW'(base_reg);
        p_lt     = (prod_reg < base_ext);
        p_gt     = (prod_reg > base_ext);
        p_err    = p_gt ? (prod_reg - base_ext) : (base_ext - prod_reg);

        div_t  = {rem_reg, num_reg[NUM_W-1]};
        div_ge = (div_t >= {1'b0, den_reg});

        res_take = res_valid_reg && !res_stall;
        out_free = !res_valid_reg || !res_stall;

        // shared multiplier operand select
        unique case (state_reg)
            S_LOD_MUL:
            begin
                mul_a = MUL_A_W'(twohz_reg);
                mul_b = MF_B;
            end
            S_LOQ_MUL:
            begin
                mul_a = div_reg;
                mul_b = MUL_B_W'(loq_trial);
            end
            S_SQ_MUL1:
            begin
                mul_a = MUL_A_W'(twohz_reg);
                mul_b = MUL_B_W'(sq_mid);
            end
            S_SQ_MUL2:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(sq_mid);
            end
            S_TD_MUL:
            begin
                mul_a = MUL_A_W'(twohz_reg);
                mul_b = MUL_B_W'(d_reg);
            end
            S_BS_MUL:
            begin
                mul_a = td_reg;
                mul_b = MUL_B_W'(bs_mid);
            end
            S_EH_MUL:
            begin
                mul_a = td_reg;
                mul_b = MUL_B_W'(hi_reg);
            end
            S_EL_MUL:
            begin
                mul_a = td_reg;
                mul_b = MUL_B_W'(lo_reg);
            end
            S_FD_MUL:
            begin
                mul_a = MUL_A_W'(best_d_reg);
                mul_b = MUL_B_W'(best_v_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_take;
        twohz_next     = twohz_reg;
        base_next      = base_reg;
        sel_next       = sel_reg;
        best_d_next    = best_d_reg;
        best_v_next    = best_v_reg;
        best_err_next  = best_err_reg;
        div_next       = div_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        sq_lo_next     = sq_lo_reg;
        sq_hi_next     = sq_hi_reg;
        d_next         = d_reg;
        d_hi_next      = d_hi_reg;
        td_next        = td_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        out_sel_next   = out_sel_reg;
        out_d_next     = out_d_reg;
        out_v_next     = out_v_reg;
        out_ach_next   = out_ach_reg;
        err_new        = best_err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    twohz_next    = twohz_c;
                    base_next     = base_c;
                    sel_next      = sel_c;
                    best_d_next   = OUT_W'(1);
                    best_v_next   = OUT_W'(1);
                    best_err_next = (twohz_c > base_c) ? PW'(twohz_c - base_c)
                                                       : PW'(base_c - twohz_c);
                    state_next    = (hz_c < HZ_FLOOR) ? S_FD_MUL : S_LOD_MUL;
                end
            end
            S_LOD_MUL:
                state_next = S_LOD_CAP;
            S_LOD_CAP:
            begin
                // lower divisor bound found bit by bit, saturating above the range
                div_next   = prod_reg[MUL_A_W-1:0];
                q_next     = '0;
                bit_next   = BIT_TOP;
                sq_lo_next = '0;
                sq_hi_next = SQ_SPAN;
                state_next = S_LOQ_MUL;
            end
            S_LOQ_MUL:
                state_next = S_LOQ_CMP;
            S_LOQ_CMP:
            begin
                if (!p_gt)
                    q_next = loq_trial;
                if (bit_reg == '0)
                    state_next = S_SQ_MUL1;
                else
                begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = S_LOQ_MUL;
                end
            end
            S_SQ_MUL1:
                state_next = S_SQ_MUL2;
            S_SQ_MUL2:
                state_next = S_SQ_CMP;
            S_SQ_CMP:
            begin
                if (!p_gt)
                    sq_lo_next = sq_mid;
                else
                    sq_hi_next = {1'b0, sq_mid};
                if ((sq_hi_next - {1'b0, sq_lo_next}) > (SQ_W+1)'(1))
                    state_next = S_SQ_MUL1;
                else
                    state_next = S_D_START;
            end
            S_D_START:
            begin
                d_hi_next = d_hi_c;
                d_next    = q_reg;
                if (q_reg > d_hi_c)
                    state_next = S_FD_MUL;
                else
                    state_next = S_TD_MUL;
            end
            S_TD_MUL:
                state_next = S_TD_CAP;
            S_TD_CAP:
            begin
                td_next    = prod_reg[MUL_A_W-1:0];
                lo_next    = QW'(1);
                hi_next    = MF_Q;
                state_next = S_BS_MUL;
            end
            S_BS_MUL:
                state_next = S_BS_CMP;
            S_BS_CMP:
            begin
                if (!p_lt && !p_gt)
                begin
                    // exact hit ends the whole search
                    if (best_err_reg != '0)
                    begin
                        best_d_next   = OUT_W'(d_reg);
                        best_v_next   = OUT_W'(bs_mid);
                        best_err_next = '0;
                    end
                    state_next = S_FD_MUL;
                end
                else
                begin
                    if (p_lt)
                        lo_next = bs_mid;
                    else
                        hi_next = bs_mid;
                    if ((hi_next - lo_next) > QW'(1))
                        state_next = S_BS_MUL;
                    else
                        state_next = S_EH_MUL;
                end
            end
            S_EH_MUL:
                state_next = S_EH_CMP;
            S_EH_CMP:
            begin
                if (p_err < best_err_reg)
                begin
                    best_d_next   = OUT_W'(d_reg);
                    best_v_next   = OUT_W'(hi_reg);
                    best_err_next = p_err;
                end
                state_next = S_EL_MUL;
            end
            S_EL_MUL:
                state_next = S_EL_CMP;
            S_EL_CMP:
            begin
                if (p_err < best_err_reg)
                begin
                    best_d_next   = OUT_W'(d_reg);
                    best_v_next   = OUT_W'(lo_reg);
                    best_err_next = p_err;
                    err_new       = p_err;
                end
                if ((err_new == '0) || (d_reg >= d_hi_reg))
                    state_next = S_FD_MUL;
                else
                begin
                    d_next     = d_reg + QW'(1);
                    state_next = S_TD_MUL;
                end
            end
            S_FD_MUL:
                state_next = S_FD_CAP;
            S_FD_CAP:
            begin
                // (base*256 + dv) / (2*dv), rounds half up
                den_next   = {prod_reg[DV_W-1:0], 1'b0};
                num_next   = (NUM_W'(base_reg) << ACH_FRAC) + NUM_W'(prod_reg[DV_W-1:0]);
                rem_next   = '0;
                cnt_next   = CNT_TOP;
                state_next = S_FD_DIV;
            end
            S_FD_DIV:
            begin
                rem_next = div_ge ? DEN_W'(div_t - {1'b0, den_reg}) : DEN_W'(div_t);
                num_next = {num_reg[NUM_W-2:0], div_ge};
                if (cnt_reg == '0)
                    state_next = S_RESULT;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_sel_next   = sel_reg;
                    out_d_next     = best_d_reg;
                    out_v_next     = best_v_reg;
                    out_ach_next   = num_reg[ACH_W-1:0];
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_a * mul_b;
        twohz_reg    <= twohz_next;
        base_reg     <= base_next;
        sel_reg      <= sel_next;
        best_d_reg   <= best_d_next;
        best_v_reg   <= best_v_next;
        best_err_reg <= best_err_next;
        div_reg      <= div_next;
        q_reg        <= q_next;
        bit_reg      <= bit_next;
        sq_lo_reg    <= sq_lo_next;
        sq_hi_reg    <= sq_hi_next;
        d_reg        <= d_next;
        d_hi_reg     <= d_hi_next;
        td_reg       <= td_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        out_sel_reg  <= out_sel_next;
        out_d_reg    <= out_d_next;
        out_v_reg    <= out_v_next;
        out_ach_reg  <= out_ach_next;
    end

    // an accepted request keeps the input side closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input not stalled after request beat");

    // value search bounds never cross
    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BS_CMP) |-> (lo_reg < hi_reg))
        else $error("value search bounds crossed");

    // chosen pair stays inside the factor range
    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (divisor != '0) && (timer_value != '0) &&
                      (divisor <= OUT_W'(MAX_FACTOR)) && (timer_value <= OUT_W'(MAX_FACTOR)))
        else $error("result pair outside factor range");

    // achieved frequency can never be zero
    a_ach_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (achieved_hz != '0))
        else $error("achieved frequency is zero");

endmodule

### tb/sv/tb_square_wave_divider_search_core.sv
`timescale 1ns / 1ps
// self-checking bench for square_wave_divider_search_core: queued request beats,
// a bit-exact predictor of the divisor search and an in-order result check
// depends on swds_pkg and the core

module tb_square_wave_divider_search_core
    import swds_pkg::*;
();

    localparam int SEARCH_SPAN = 256;
    localparam int RANDOM_PER_PHASE = 145;
    localparam int REPORT_LIMIT = 10;

    localparam logic [HZ_W-1:0] EDGE_REQUESTS [21] = '{
        25'd0, 25'd1, 25'd2, 25'd7, 25'd8, 25'd9, 25'd30, 25'd31, 25'd91, 25'd92,
        25'd366, 25'd367, 25'd1000, 25'd1465, 25'd12000, 25'd375000,
        25'd23999999, 25'd24000000, 25'd24000001, 25'h1FFFFFF, 25'h1000000
    };

    // sender idle and receiver stall percentages per phase
    localparam int PHASES = 5;
    localparam int SEND_IDLE [PHASES] = '{0, 0, 86, 0, 34};
    localparam int RECV_STALL [PHASES] = '{0, 0, 0, 86, 34};

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [OUT_W-1:0] div_val;
        logic [OUT_W-1:0] tmr_val;
        logic [ACH_W-1:0] ach;
    } divider_setting_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [HZ_W-1:0]    requested_hz;
    logic               res_valid;
    logic               res_stall;
    logic [SEL_W-1:0]   base_select;
    logic [OUT_W-1:0]   divisor;
    logic [OUT_W-1:0]   timer_value;
    logic [ACH_W-1:0]   achieved_hz;

    logic [HZ_W-1:0]    hz_pending [$];
    divider_setting_t   expected_settings [$];
    int unsigned        req_issued;
    int unsigned        req_taken;
    int unsigned        mismatch_count;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;

    square_wave_divider_search_core #(
        .MAX_FACTOR (SEARCH_SPAN)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .requested_hz (requested_hz),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .base_select  (base_select),
        .divisor      (divisor),
        .timer_value  (timer_value),
        .achieved_hz  (achieved_hz)
    );

    function automatic longint unsigned gap(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic divider_setting_t predict_setting(logic [HZ_W-1:0] req);
        longint unsigned hz;
        longint unsigned base_hz;
        longint unsigned two_hz;
        longint unsigned d_lo;
        longint unsigned d_hi;
        longint unsigned d;
        longint unsigned sq_lo;
        longint unsigned sq_hi;
        longint unsigned sq_mid;
        longint unsigned prod;
        longint unsigned err;
        longint unsigned best_err;
        longint unsigned dv;
        longint unsigned ach;
        longint unsigned best_d;
        longint unsigned best_v;
        longint unsigned lo_v;
        longint unsigned hi_v;
        longint unsigned mid_v;
        logic [SEL_W-1:0] sel;
        bit hit;
        divider_setting_t r;

        hz = req;
        if (hz == 0)
            hz = 1;
        if (hz > HZ_CEIL)
            hz = HZ_CEIL;

        if (hz > THR_48M)
        begin
            base_hz = BASE_48M;
            sel = SEL_48M;
        end
        else if (hz > THR_12M)
        begin
            base_hz = BASE_12M;
            sel = SEL_12M;
        end
        else if (hz > THR_4M)
        begin
            base_hz = BASE_4M;
            sel = SEL_4M;
        end
        else
        begin
            base_hz = BASE_1M;
            sel = SEL_1M;
        end

        two_hz = 2 * hz;
        best_d = 1;
        best_v = 1;
        best_err = gap(two_hz, base_hz);
        hit = 1'b0;

        if (hz >= HZ_FLOOR)
        begin
            d_lo = base_hz / (two_hz * SEARCH_SPAN);
            // largest s with s*s*2hz <= base
            sq_lo = 0;
            sq_hi = 1024;
            while (sq_hi - sq_lo > 1)
            begin
                sq_mid = (sq_lo + sq_hi) / 2;
                if (sq_mid * sq_mid * two_hz <= base_hz)
                    sq_lo = sq_mid;
                else
                    sq_hi = sq_mid;
            end
            d_hi = sq_lo + 1;
            if (d_hi > SEARCH_SPAN)
                d_hi = SEARCH_SPAN;

            for (d = d_lo; d <= d_hi && !hit; d++)
            begin
                lo_v = 1;
                hi_v = SEARCH_SPAN;
                while (hi_v - lo_v > 1 && !hit)
                begin
                    mid_v = (hi_v + lo_v) / 2;
                    prod = two_hz * d * mid_v;
                    if (prod < base_hz)
                        lo_v = mid_v;
                    else if (prod > base_hz)
                        hi_v = mid_v;
                    else
                    begin
                        // exact product ends the whole search
                        if (best_err > 0)
                        begin
                            best_d = d;
                            best_v = mid_v;
                            best_err = 0;
                        end
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    err = gap(two_hz * d * hi_v, base_hz);
                    if (err < best_err)
                    begin
                        best_d = d;
                        best_v = hi_v;
                        best_err = err;
                    end
                    err = gap(two_hz * d * lo_v, base_hz);
                    if (err < best_err)
                    begin
                        best_d = d;
                        best_v = lo_v;
                        best_err = err;
                    end
                    if (best_err == 0)
                        hit = 1'b1;
                end
            end
        end

        dv = best_d * best_v;
        ach = (base_hz * 256 + dv) / (2 * dv);

        r.sel = sel;
        r.div_val = OUT_W'(best_d);
        r.tmr_val = OUT_W'(best_v);
        r.ach = ACH_W'(ach);
        return r;
    endfunction

    function automatic logic [HZ_W-1:0] pick_request();
        int unsigned kind;
        int unsigned e;
        int unsigned k;
        logic [HZ_W-1:0] hz;

        kind = $urandom_range(99);
        if (kind < 40)
        begin
            // spread evenly over octaves
            e = $urandom_range(24, 3);
            hz = HZ_W'($urandom_range((32'd1 << (e + 1)) - 1, 32'd1 << e));
        end
        else if (kind < 60)
        begin
            // exact divisors of 24 MHz, which can give zero-error pairs
            k = (32'd1 << $urandom_range(9)) * ($urandom_range(1) ? 3 : 1)
                * (5 ** $urandom_range(6));
            hz = HZ_W'(32'd24000000 / k);
        end
        else if (kind < 70)
        begin
            case ($urandom_range(3))
                0: hz = HZ_W'($urandom_range(40));
                1: hz = THR_48M + HZ_W'($urandom_range(2)) - HZ_W'(1);
                2: hz = THR_12M + HZ_W'($urandom_range(2)) - HZ_W'(1);
                default: hz = THR_4M + HZ_W'($urandom_range(2)) - HZ_W'(1);
            endcase
        end
        else if (kind < 85)
            // widest divisor ranges on the 48 MHz base
            hz = HZ_W'($urandom_range(3000, 700));
        else
            hz = HZ_W'($urandom());
        return hz;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver and result stall, all changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_issued == req_taken)
            begin
                if (hz_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    requested_hz <= hz_pending.pop_front();
                    req_valid <= 1'b1;
                    req_issued++;
                end
                else
                    req_valid <= 1'b0;
            end
            res_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // monitor: predict on each request beat, check each result beat
    always @(posedge clk)
    begin
        divider_setting_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_settings.push_back(predict_setting(requested_hz));
                req_taken++;
            end
            if (res_valid && !res_stall)
            begin
                if (expected_settings.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: sel %0d div %0d val %0d ach %0d",
                                 base_select, divisor, timer_value, achieved_hz);
                end
                else
                begin
                    want = expected_settings.pop_front();
                    if (base_select !== want.sel || divisor !== want.div_val
                        || timer_value !== want.tmr_val || achieved_hz !== want.ach)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.sel, want.div_val, want.tmr_val, want.ach,
                                     base_select, divisor, timer_value, achieved_hz);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        requested_hz = '0;
        res_stall = 1'b0;
        req_issued = 0;
        req_taken = 0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            sender_idle_pct = SEND_IDLE[ph];
            receiver_stall_pct = RECV_STALL[ph];
            if (ph == 0)
            begin
                foreach (EDGE_REQUESTS[i])
                    hz_pending.push_back(EDGE_REQUESTS[i]);
            end
            else
            begin
                repeat (RANDOM_PER_PHASE)
                    hz_pending.push_back(pick_request());
            end
            while (hz_pending.size() != 0 || req_issued != req_taken
                   || expected_settings.size() != 0)
                @(negedge clk);
        end

        // allow a stray result to surface
        repeat (2000) @(posedge clk);
        if (mismatch_count == 0 && expected_settings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
